// File: rtl/core/sic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sic_pkg;

   localparam int unsigned HDR_LEN = 52;
   localparam int unsigned HDR_IDX_W = 6;

   localparam logic [31:0] MAGIC_VALUE = 32'h534D_4752;
   localparam logic [15:0] VERSION_VALUE = 16'd1;
   localparam logic [31:0] HASH_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME = 32'd16777619;

   localparam int unsigned PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PH_HEADER = 2'd0;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd1;
   localparam logic [PHASE_W-1:0] PH_SKIP = 2'd2;

   localparam int unsigned STATUS_W = 3;
   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT_HEADER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SHORT_PAYLOAD = 3'd5;

   localparam int unsigned RSP_DATA_W = 96;
   localparam int unsigned RSP_USER_W = 2;

   typedef struct packed {
      logic [31:0] payload_length;
      logic [31:0] port_number;
      logic [15:0] source_kind;
      logic hash_ok;
      logic [STATUS_W-1:0] status;
      logic [7:0] payload_byte;
   } rsp_fields_type;

   function automatic logic [31:0] shift32(input logic [31:0] w, input logic [7:0] b,
                                           input logic be);
      return be ? {w[23:0], b} : {b, w[31:8]};
   endfunction

   function automatic logic [15:0] shift16(input logic [15:0] w, input logic [7:0] b,
                                           input logic be);
      return be ? {w[7:0], b} : {b, w[15:8]};
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/save_image_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// A result word is registered onto rsp in the cycle after its request word is accepted.
// Throughput: one request word per cycle while rsp is not stalled; the FNV-1a update
// (xor, multiply by the prime) on the running hash register closes within that cycle.
// Reset (synchronous, active high): header phase at byte 0, no result pending,
// header byte order big endian.
module save_image_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // data_byte[7:0]
   input  wire         req_tlast,   // end_of_image
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [95:0] rsp_tdata,   // payload_byte[7:0], status[10:8], hash_ok[11],
                                    // source_kind[27:12], port_number[59:28],
                                    // payload_length[91:60], zero[95:92]
   output logic [1:0]  rsp_tuser,   // byte_valid[0], verdict_valid[1]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_data     // big_endian_header
);

   logic be_ff;
   logic [sic_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [sic_pkg::HDR_IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] magic_ff, magic_in;
   logic [15:0] version_ff, version_in;
   logic [15:0] source_ff, source_in;
   logic [31:0] port_ff, port_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] checksum_ff, checksum_in;
   logic [31:0] hash_ff, hash_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [sic_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [sic_pkg::RSP_USER_W-1:0] rsp_user_ff;

   logic req_fire;
   logic res_fire;
   logic byte_valid, verdict_valid;
   sic_pkg::rsp_fields_type res;
   logic [31:0] hash_mix, hash_next, count_next;
   logic [sic_pkg::STATUS_W-1:0] hdr_status;

   assign csr_ready = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire = req_tvalid && req_tready;

   assign hash_mix = hash_ff ^ {24'd0, req_tdata};
   assign hash_next = 32'(hash_mix * sic_pkg::HASH_PRIME);
   assign count_next = count_ff + 32'd1;

   always_comb begin
      if (magic_ff != sic_pkg::MAGIC_VALUE) begin
         hdr_status = sic_pkg::ST_BAD_MAGIC;
      end else if (version_ff != sic_pkg::VERSION_VALUE) begin
         hdr_status = sic_pkg::ST_BAD_VERSION;
      end else if (size_ff == 32'd0) begin
         hdr_status = sic_pkg::ST_ZERO_SIZE;
      end else begin
         hdr_status = sic_pkg::ST_OK;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      count_in = count_ff;
      magic_in = magic_ff;
      version_in = version_ff;
      source_in = source_ff;
      port_in = port_ff;
      size_in = size_ff;
      checksum_in = checksum_ff;
      hash_in = hash_ff;
      res_fire = 1'b0;
      byte_valid = 1'b0;
      verdict_valid = 1'b0;
      res = '0;
      if (req_fire) begin
         case (phase_ff)
            sic_pkg::PH_HEADER: begin
               if (hdr_idx_ff < 6'd4) begin
                  magic_in = sic_pkg::shift32(magic_ff, req_tdata, be_ff);
               end else if (hdr_idx_ff < 6'd6) begin
                  version_in = sic_pkg::shift16(version_ff, req_tdata, be_ff);
               end else if (hdr_idx_ff < 6'd8) begin
                  source_in = sic_pkg::shift16(source_ff, req_tdata, be_ff);
               end else if (hdr_idx_ff < 6'd12) begin
                  port_in = sic_pkg::shift32(port_ff, req_tdata, be_ff);
               end else if (hdr_idx_ff < 6'd16) begin
                  size_in = sic_pkg::shift32(size_ff, req_tdata, be_ff);
               end else if (hdr_idx_ff < 6'd20) begin
                  checksum_in = sic_pkg::shift32(checksum_ff, req_tdata, be_ff);
               end
               if (hdr_idx_ff != sic_pkg::HDR_IDX_W'(sic_pkg::HDR_LEN - 1)) begin
                  hdr_idx_in = hdr_idx_ff + 6'd1;
                  if (req_tlast) begin
                     res_fire = 1'b1;
                     verdict_valid = 1'b1;
                     res.status = sic_pkg::ST_SHORT_HEADER;
                     hdr_idx_in = '0;
                  end
               end else begin
                  hdr_idx_in = '0;
                  if (hdr_status != sic_pkg::ST_OK || req_tlast) begin
                     res_fire = 1'b1;
                     verdict_valid = 1'b1;
                     res.status = (hdr_status != sic_pkg::ST_OK) ? hdr_status
                                                                 : sic_pkg::ST_SHORT_PAYLOAD;
                     res.source_kind = source_ff;
                     res.port_number = port_ff;
                     res.payload_length = size_ff;
                     phase_in = req_tlast ? sic_pkg::PH_HEADER : sic_pkg::PH_SKIP;
                  end else begin
                     phase_in = sic_pkg::PH_PAYLOAD;
                     count_in = '0;
                     hash_in = sic_pkg::HASH_BASIS;
                  end
               end
            end
            sic_pkg::PH_PAYLOAD: begin
               hash_in = hash_next;
               count_in = count_next;
               res_fire = 1'b1;
               byte_valid = 1'b1;
               res.payload_byte = req_tdata;
               if (count_next == size_ff || req_tlast) begin
                  verdict_valid = 1'b1;
                  res.source_kind = source_ff;
                  res.port_number = port_ff;
                  res.payload_length = size_ff;
                  if (count_next == size_ff) begin
                     res.status = sic_pkg::ST_OK;
                     res.hash_ok = (hash_next == checksum_ff);
                     phase_in = req_tlast ? sic_pkg::PH_HEADER : sic_pkg::PH_SKIP;
                  end else begin
                     res.status = sic_pkg::ST_SHORT_PAYLOAD;
                     phase_in = sic_pkg::PH_HEADER;
                  end
                  hdr_idx_in = '0;
               end
            end
            default: begin
               if (req_tlast) begin
                  phase_in = sic_pkg::PH_HEADER;
                  hdr_idx_in = '0;
               end
            end
         endcase
      end
   end

   always_comb begin
      if (res_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         be_ff <= 1'b1;
         phase_ff <= sic_pkg::PH_HEADER;
         hdr_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            be_ff <= csr_data;
         end
         phase_ff <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         magic_ff <= '0;
         version_ff <= '0;
         source_ff <= '0;
         port_ff <= '0;
         size_ff <= '0;
         checksum_ff <= '0;
         hash_ff <= sic_pkg::HASH_BASIS;
      end else begin
         count_ff <= count_in;
         magic_ff <= magic_in;
         version_ff <= version_in;
         source_ff <= source_in;
         port_ff <= port_in;
         size_ff <= size_in;
         checksum_ff <= checksum_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_data_ff <= {4'd0, res};
         rsp_user_ff <= {verdict_valid, byte_valid};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_word_has_content: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] || rsp_tuser[1]))
      else $error("result word carries neither a byte nor a verdict");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:8] != 3'd6 && rsp_tdata[10:8] != 3'd7))
      else $error("unused status code");

   a_hash_ok_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[11]) |-> (rsp_tuser[1] && rsp_tdata[10:8] == sic_pkg::ST_OK))
      else $error("hash_ok set without ok verdict");

   a_short_header_no_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[10:8] == sic_pkg::ST_SHORT_HEADER)
         |-> (rsp_tdata[91:12] == 80'd0 && !rsp_tuser[0]))
      else $error("short header verdict carries header fields");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (phase_ff == sic_pkg::PH_HEADER && hdr_idx_ff == '0))
      else $error("end of image did not return to header start");

   a_payload_count_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sic_pkg::PH_PAYLOAD) |-> (count_ff < size_ff))
      else $error("payload count ran past size");

endmodule

`default_nettype wire

// File: tb/sv/save_image_monitor.sv
`timescale 1ns / 1ps

module save_image_monitor
   import sic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          error_count,
   output int          results_in_flight
);

   typedef struct packed {
      logic           verdict_valid;
      logic           byte_valid;
      rsp_fields_type fields;
   } scan_word_type;

   scan_word_type        scan_results[$];
   logic                 big_endian;
   logic [PHASE_W-1:0]   phase;
   logic [HDR_IDX_W-1:0] hdr_idx;
   logic [31:0]          pay_cnt;
   logic [31:0]          hdr_magic;
   logic [15:0]          hdr_version;
   logic [15:0]          hdr_source;
   logic [31:0]          hdr_port;
   logic [31:0]          hdr_length;
   logic [31:0]          hdr_checksum;
   logic [31:0]          running_fnv;

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         note_mismatch(what, got, want);
   endtask

   task automatic scan_image_byte(input logic [7:0] b, input logic last);
      scan_word_type       r;
      logic [STATUS_W-1:0] st;
      r = '0;
      st = ST_OK;
      case (phase)
         PH_HEADER: begin
            if (hdr_idx < 4)
               hdr_magic = big_endian ? {hdr_magic[23:0], b} : {b, hdr_magic[31:8]};
            else if (hdr_idx < 6)
               hdr_version = big_endian ? {hdr_version[7:0], b} : {b, hdr_version[15:8]};
            else if (hdr_idx < 8)
               hdr_source = big_endian ? {hdr_source[7:0], b} : {b, hdr_source[15:8]};
            else if (hdr_idx < 12)
               hdr_port = big_endian ? {hdr_port[23:0], b} : {b, hdr_port[31:8]};
            else if (hdr_idx < 16)
               hdr_length = big_endian ? {hdr_length[23:0], b} : {b, hdr_length[31:8]};
            else if (hdr_idx < 20)
               hdr_checksum = big_endian ? {hdr_checksum[23:0], b}
                                         : {b, hdr_checksum[31:8]};
            if (hdr_idx != HDR_LEN - 1) begin
               hdr_idx = hdr_idx + 1'b1;
               if (last) begin
                  r.verdict_valid = 1'b1;
                  r.fields.status = ST_SHORT_HEADER;
               end
            end else begin
               if (hdr_magic != MAGIC_VALUE)
                  st = ST_BAD_MAGIC;
               else if (hdr_version != VERSION_VALUE)
                  st = ST_BAD_VERSION;
               else if (hdr_length == '0)
                  st = ST_ZERO_SIZE;
               else if (last)
                  st = ST_SHORT_PAYLOAD;
               if (st != ST_OK) begin
                  r.verdict_valid = 1'b1;
                  r.fields.status = st;
                  phase = PH_SKIP;
               end else begin
                  phase = PH_PAYLOAD;
                  pay_cnt = '0;
                  running_fnv = HASH_BASIS;
               end
            end
         end
         PH_PAYLOAD: begin
            running_fnv = (running_fnv ^ {24'd0, b}) * HASH_PRIME;
            pay_cnt = pay_cnt + 32'd1;
            r.byte_valid = 1'b1;
            r.fields.payload_byte = b;
            if (pay_cnt == hdr_length) begin
               r.verdict_valid = 1'b1;
               r.fields.status = ST_OK;
               r.fields.hash_ok = (running_fnv == hdr_checksum);
               phase = PH_SKIP;
            end else if (last) begin
               r.verdict_valid = 1'b1;
               r.fields.status = ST_SHORT_PAYLOAD;
            end
         end
         default: ;
      endcase
      if (r.verdict_valid && r.fields.status != ST_SHORT_HEADER) begin
         r.fields.source_kind = hdr_source;
         r.fields.port_number = hdr_port;
         r.fields.payload_length = hdr_length;
      end
      if (last) begin
         phase = PH_HEADER;
         hdr_idx = '0;
      end
      if (r.verdict_valid || r.byte_valid)
         scan_results.push_back(r);
   endtask

   always @(posedge clock) begin : watch
      scan_word_type  want;
      rsp_fields_type got;
      if (reset) begin
         big_endian = 1'b1;
         phase = PH_HEADER;
         hdr_idx = '0;
         pay_cnt = '0;
         hdr_magic = '0;
         hdr_version = '0;
         hdr_source = '0;
         hdr_port = '0;
         hdr_length = '0;
         hdr_checksum = '0;
         running_fnv = HASH_BASIS;
         scan_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            big_endian = csr_data;
         if (req_tvalid && req_tready)
            scan_image_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_fields_type)-1:0];
            if (scan_results.size() == 0) begin
               note_mismatch("word with nothing pending", {30'd0, rsp_tuser}, '0);
            end else begin
               want = scan_results.pop_front();
               compare_field("byte_valid", 32'(rsp_tuser[0]), 32'(want.byte_valid));
               compare_field("verdict_valid", 32'(rsp_tuser[1]), 32'(want.verdict_valid));
               compare_field("payload_byte", 32'(got.payload_byte),
                             32'(want.fields.payload_byte));
               compare_field("status", 32'(got.status), 32'(want.fields.status));
               compare_field("hash_ok", 32'(got.hash_ok), 32'(want.fields.hash_ok));
               compare_field("source_kind", 32'(got.source_kind),
                             32'(want.fields.source_kind));
               compare_field("port_number", got.port_number, want.fields.port_number);
               compare_field("payload_length", got.payload_length,
                             want.fields.payload_length);
            end
         end
      end
      results_in_flight <= scan_results.size();
   end

endmodule

// File: tb/sv/tb_save_image_checker.sv
`timescale 1ns / 1ps

module tb_save_image_checker;
   import sic_pkg::*;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_data = 1'b1;

   int          error_count;
   int          results_in_flight;
   int          send_idle = 8;
   int          recv_idle = 72;
   int          bytes_sent = 0;
   logic        header_be = 1'b1;
   logic [7:0]  image[$];

   save_image_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   save_image_monitor scan (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tlast         (req_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .error_count       (error_count),
      .results_in_flight (results_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #5_000_000;
      $display("save_image_checker verification failed");
      $finish;
   end

   task automatic send_word(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // send the first count bytes, last flag on the final one, then drop the rest
   task automatic send_image(input int unsigned count);
      for (int i = 0; i < count; i++)
         send_word(image[i], i == count - 1);
      image.delete();
   endtask

   task automatic add_field(input logic [31:0] v, input int n);
      for (int i = 0; i < n; i++)
         image.push_back(header_be ? v[8*(n-1-i) +: 8] : v[8*i +: 8]);
   endtask

   task automatic put_image(input logic [31:0] magic, input logic [15:0] version,
                            input logic [15:0] source, input logic [31:0] port,
                            input logic [31:0] length, input int unsigned pay_bytes,
                            input int unsigned tail, input bit sum_right,
                            input int unsigned cut);
      logic [7:0]  payload[$];
      logic [7:0]  b;
      logic [31:0] fnv;
      fnv = HASH_BASIS;
      repeat (pay_bytes) begin
         b = 8'($urandom_range(255));
         payload.push_back(b);
         fnv = (fnv ^ {24'd0, b}) * HASH_PRIME;
      end
      add_field(magic, 4);
      add_field({16'd0, version}, 2);
      add_field({16'd0, source}, 2);
      add_field(port, 4);
      add_field(length, 4);
      add_field(sum_right ? fnv : $urandom, 4);
      repeat (32) image.push_back(8'($urandom_range(255)));
      foreach (payload[i]) image.push_back(payload[i]);
      repeat (tail) image.push_back(8'($urandom_range(255)));
      send_image(cut != 0 ? cut : image.size());
   endtask

   task automatic run_directed();
      put_image(MAGIC_VALUE, VERSION_VALUE, 16'hFFFF, 32'h8000_0000, 1, 1, 0, 1, 0);
      put_image(MAGIC_VALUE, VERSION_VALUE, 16'h0000, 32'h7FFF_FFFF, 3, 3, 3, 0, 0);
      put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, 4, 4, 0, 1, 1);
      put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, 4, 4, 0, 1, 51);
      put_image(32'h0, VERSION_VALUE, 16'($urandom), $urandom, 4, 0, 2, 1, 0);
      put_image(MAGIC_VALUE, 16'h0000, 16'($urandom), $urandom, 4, 0, 0, 1, 0);
      put_image(MAGIC_VALUE, 16'hFFFF, 16'($urandom), $urandom, 4, 0, 1, 1, 0);
      put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, 0, 0, 2, 1, 0);
      put_image(32'hFFFF_FFFF, 16'h0000, 16'($urandom), $urandom, 0, 0, 0, 1, 0);
      put_image(MAGIC_VALUE, 16'd2, 16'($urandom), $urandom, 0, 0, 1, 1, 0);
      put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, 5, 0, 0, 1, 0);
      put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, 32'hFFFF_FFFF,
                4, 0, 1, 0);
   endtask

   task automatic random_image();
      int unsigned n;
      int unsigned tail;
      int unsigned pick;
      logic [15:0] ver;
      logic [31:0] bad_magic;
      n = ($urandom_range(9) == 0) ? $urandom_range(250, 120) : $urandom_range(24, 1);
      tail = $urandom_range(1) ? 0 : $urandom_range(6, 1);
      pick = $urandom_range(99);
      ver = $urandom_range(1) ? 16'd0 : 16'($urandom_range(65535, 2));
      bad_magic = $urandom_range(1) ? (MAGIC_VALUE ^ (32'd1 << $urandom_range(31)))
                                    : $urandom;
      if (pick < 55)
         put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, n, n, tail,
                   $urandom_range(3) != 0, 0);
      else if (pick < 70)
         put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, n,
                   $urandom_range(n - 1), 0, 1, 0);
      else if (pick < 76)
         put_image(bad_magic, VERSION_VALUE, 16'($urandom), $urandom, n, 0, tail, 1, 0);
      else if (pick < 82)
         put_image(MAGIC_VALUE, ver, 16'($urandom), $urandom, n, 0, tail, 1, 0);
      else if (pick < 86)
         put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, 0, 0, tail, 1, 0);
      else if (pick < 94)
         put_image(MAGIC_VALUE, VERSION_VALUE, 16'($urandom), $urandom, n, n, 0, 1,
                   $urandom_range(51, 1));
      else begin
         repeat ($urandom_range(80, 1)) image.push_back(8'($urandom_range(255)));
         send_image(image.size());
      end
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_in_flight != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_order(input logic be);
      csr_valid <= 1'b1;
      csr_data <= be;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      header_be = be;
   endtask

   initial begin : stimulus
      int mark;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_quiet();
      write_order(1'b0);
      run_directed();
      for (int round = 0; round < 3; round++) begin
         case (round)
            0: begin
               send_idle = 8;
               recv_idle = 72;
            end
            1: begin
               send_idle = 72;
               recv_idle = 8;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         for (int half = 0; half < 2; half++) begin
            wait_quiet();
            write_order(half == 0);
            mark = bytes_sent;
            while (bytes_sent - mark < 70) random_image();
         end
      end
      wait_quiet();
      if (error_count == 0)
         $display("save_image_checker verification clean");
      else
         $display("save_image_checker verification failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/sic_pkg.sv
rtl/core/save_image_checker.sv
tb/sv/save_image_monitor.sv
tb/sv/tb_save_image_checker.sv
